// File: design/trbp_pkg.sv
// Shared types and constants for the command ring producer.
`timescale 1ns / 1ps
package trbp_pkg;

	// Largest slot count the ring logic supports (8-bit slot index)
	localparam int unsigned SLOT_CAP = 256;

	// Configuration register indexes
	localparam logic REG_RING_SLOTS = 1'b0;
	localparam logic REG_RING_BASE  = 1'b1;

	// Command codes carried on the input selector
	localparam logic [1:0] CMD_ENQUEUE  = 2'd0;
	localparam logic [1:0] CMD_COMPLETE = 2'd1;
	localparam logic [1:0] CMD_RESET    = 2'd2;

	// Outcome codes reported with each result
	localparam logic [1:0] OUT_WRITTEN  = 2'd0;
	localparam logic [1:0] OUT_FULL     = 2'd1;
	localparam logic [1:0] OUT_ABSORBED = 2'd2;
	localparam logic [1:0] OUT_RESET    = 2'd3;

	// Link descriptor control word: type 6 at bit 10, toggle cycle at bit 1
	localparam logic [31:0] LINK_CONTROL = 32'h0000_1802;

	// One accepted input item
	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] desc_parameter;
		logic [31:0] desc_status;
		logic [31:0] desc_control;
		logic [63:0] completed_address;
	} item_t;

	// One result item
	typedef struct packed {
		logic [1:0]  outcome;
		logic        write_valid;
		logic [7:0]  write_slot;
		logic [63:0] write_parameter;
		logic [31:0] write_status;
		logic [31:0] write_control;
		logic        last;
		logic [7:0]  produce_index;
		logic [7:0]  consume_index;
		logic        produce_cycle;
		logic        consume_cycle;
	} result_t;

	// Results produced by one pass over an item
	typedef struct packed {
		logic    has_result;
		logic    two_results;
		result_t first;
		result_t second;
	} step_out_t;

endpackage

// File: design/trbp_step.sv
// Ring pointer state and the single-pass update for one command.
`timescale 1ns / 1ps
module trbp_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  trbp_pkg::item_t    item,
	input  logic [8:0]         ring_slots,
	input  logic [63:0]        ring_base,
	output trbp_pkg::step_out_t step
);
	import trbp_pkg::*;

	logic [7:0]  head_q;
	logic [7:0]  tail_q;
	logic        pcyc_q;
	logic        ccyc_q;

	logic [7:0]  head_d;
	logic [7:0]  tail_d;
	logic        pcyc_d;
	logic        ccyc_d;

	logic [7:0]  link_slot;
	logic [63:0] addr_offset;
	logic [59:0] done_index;
	logic [8:0]  done_next;
	logic        done_wrap;
	logic [8:0]  head_next;
	logic        head_wrap;
	logic        has_room;
	result_t     res_a;
	result_t     res_b;

	// Clamp the slot count to [2, SLOT_CAP]; link slot is the last one
	always_comb begin
		if (ring_slots < 9'd2) begin
			link_slot = 8'd1;
		end else if (ring_slots > 9'(SLOT_CAP)) begin
			link_slot = 8'(SLOT_CAP - 1);
		end else begin
			link_slot = 8'(ring_slots - 9'd1);
		end
	end

	// Completion address to dequeue index
	assign addr_offset = item.completed_address - ring_base;
	assign done_index  = addr_offset[63:4];
	assign done_next   = {1'b0, done_index[7:0]} + 9'd1;
	assign done_wrap   = (|done_index[59:8]) || (done_next >= {1'b0, link_slot});

	// Room check and head advance for an enqueue
	assign has_room  = (ccyc_q == pcyc_q) ? (head_q >= tail_q) : (head_q < tail_q);
	assign head_next = {1'b0, head_q} + 9'd1;
	assign head_wrap = head_next >= {1'b0, link_slot};

	// Next pointer state
	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		pcyc_d = pcyc_q;
		ccyc_d = ccyc_q;
		case (item.cmd)
			CMD_RESET: begin
				head_d = '0;
				tail_d = '0;
				pcyc_d = 1'b1;
				ccyc_d = 1'b1;
			end
			CMD_COMPLETE: begin
				if (done_wrap) begin
					tail_d = '0;
					ccyc_d = ~ccyc_q;
				end else begin
					tail_d = done_next[7:0];
					if (done_next[7:0] < tail_q) begin
						ccyc_d = ~ccyc_q;
					end
				end
			end
			CMD_ENQUEUE: begin
				if (has_room) begin
					if (head_wrap) begin
						head_d = '0;
						pcyc_d = ~pcyc_q;
					end else begin
						head_d = head_next[7:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Result items
	always_comb begin
		res_a = '0;
		res_b = '0;
		res_a.last          = 1'b1;
		res_a.produce_index = head_d;
		res_a.consume_index = tail_d;
		res_a.produce_cycle = pcyc_d;
		res_a.consume_cycle = ccyc_d;
		res_b.outcome         = OUT_WRITTEN;
		res_b.write_valid     = 1'b1;
		res_b.write_slot      = link_slot;
		res_b.write_parameter = ring_base;
		res_b.write_control   = LINK_CONTROL | {31'd0, pcyc_q};
		res_b.last            = 1'b1;
		res_b.produce_index   = head_d;
		res_b.consume_index   = tail_d;
		res_b.produce_cycle   = pcyc_d;
		res_b.consume_cycle   = ccyc_d;
		step.has_result  = 1'b1;
		step.two_results = 1'b0;
		case (item.cmd)
			CMD_RESET: begin
				res_a.outcome         = OUT_RESET;
				res_a.write_valid     = 1'b1;
				res_a.write_slot      = link_slot;
				res_a.write_parameter = ring_base;
				res_a.write_control   = LINK_CONTROL | 32'd1;
			end
			CMD_COMPLETE: begin
				res_a.outcome = OUT_ABSORBED;
			end
			CMD_ENQUEUE: begin
				if (has_room) begin
					res_a.outcome         = OUT_WRITTEN;
					res_a.write_valid     = 1'b1;
					res_a.write_slot      = head_q;
					res_a.write_parameter = item.desc_parameter;
					res_a.write_status    = item.desc_status;
					res_a.write_control   = {item.desc_control[31:1], pcyc_q};
					res_a.last            = ~head_wrap;
					step.two_results      = head_wrap;
				end else begin
					res_a.outcome = OUT_FULL;
				end
			end
			default: begin
				step.has_result = 1'b0;
			end
		endcase
		step.first  = res_a;
		step.second = res_b;
	end

	// Commit the pointer state when the item is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			pcyc_q <= 1'b1;
			ccyc_q <= 1'b1;
		end else if (advance) begin
			head_q <= head_d;
			tail_q <= tail_d;
			pcyc_q <= pcyc_d;
			ccyc_q <= ccyc_d;
		end
	end

endmodule

// File: design/trbp_out.sv
// Result register with a pending slot for the trailing link write.
`timescale 1ns / 1ps
module trbp_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  trbp_pkg::step_out_t step,
	output logic                take_new,
	output logic                out_valid,
	input  logic                out_ready,
	output trbp_pkg::result_t   out_data
);
	import trbp_pkg::*;

	logic    out_valid_q;
	logic    pend_q;
	result_t out_q;
	result_t pend_data_q;
	logic    out_free;

	assign out_free  = ~out_valid_q | out_ready;
	assign take_new  = ~pend_q & out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Track output and pending occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (out_free) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (load) begin
				out_valid_q <= 1'b1;
				pend_q      <= step.two_results;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Move result payloads
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_q) begin
				out_q <= pend_data_q;
			end else if (load) begin
				out_q       <= step.first;
				pend_data_q <= step.second;
			end
		end
	end

endmodule

// File: design/trb_command_ring_producer.sv
// Top level of the command ring producer: ports, registers, input stage.
`timescale 1ns / 1ps
// Producer side of a cycle-bit command ring of 16-byte descriptors.
// Input stream (s_*): s_tuser carries the command (enqueue, completion
// event, ring reset); s_tdata carries the descriptor and completed address.
// Output stream (m_*): one result per command, none for cmd code 3, and
// two for an enqueue that reaches the link slot (descriptor write, then
// link descriptor write). m_tlast marks the final result of a command;
// m_tuser holds the outcome and the write flag. Ring slot count and base
// address come from the configuration write port; the user must write
// them only while the block is idle; the block does not enforce it.
// An input passes the input register, then the result register.
// Throughput: one command per cycle while m_tready is high, set by the
// single result register; a wrapping enqueue holds the input side while
// its link write drains from the pending slot.
// Reset: pointers clear to zero, both cycle states to one, slot count to
// 256, base to zero; no result is emitted. When m_tready is low the result
// register and pending slot hold, and s_tready drops once the input
// register is full.
module trb_command_ring_producer (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [63:0] desc_parameter, [95:64] desc_status, [127:96] desc_control,
	// [191:128] completed_address
	input  logic [191:0] s_tdata,
	// [1:0] cmd
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [7:0] write_slot, [71:8] write_parameter, [103:72] write_status,
	// [135:104] write_control, [143:136] produce_index,
	// [151:144] consume_index, [152] produce_cycle, [153] consume_cycle,
	// [159:154] zero
	output logic [159:0] m_tdata,
	// [1:0] outcome, [2] write_valid
	output logic [2:0]   m_tuser,
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [63:0]  cfg_data
);
	import trbp_pkg::*;

	logic [8:0]  ring_slots_q;
	logic [63:0] ring_base_q;
	logic        valid_s1;
	item_t       item_s1;
	logic        take_new;
	logic        advance;
	step_out_t   step;
	result_t     res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_slots_q <= 9'd256;
			ring_base_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RING_SLOTS: ring_slots_q <= cfg_data[8:0];
				REG_RING_BASE:  ring_base_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input register: refill when empty or when its item advances
	assign advance  = valid_s1 & take_new;
	assign s_tready = ~valid_s1 | take_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready & s_tvalid) begin
			item_s1.cmd               <= s_tuser;
			item_s1.desc_parameter    <= s_tdata[63:0];
			item_s1.desc_status       <= s_tdata[95:64];
			item_s1.desc_control      <= s_tdata[127:96];
			item_s1.completed_address <= s_tdata[191:128];
		end
	end

	trbp_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item       (item_s1),
		.ring_slots (ring_slots_q),
		.ring_base  (ring_base_q),
		.step       (step)
	);

	trbp_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance & step.has_result),
		.step      (step),
		.take_new  (take_new),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	// Pack the result onto the output stream
	assign m_tdata = {6'd0, res.consume_cycle, res.produce_cycle, res.consume_index,
		res.produce_index, res.write_control, res.write_status, res.write_parameter,
		res.write_slot};
	assign m_tuser = {res.write_valid, res.outcome};
	assign m_tlast = res.last;

endmodule
